// ===== src/maze_dfs_explorer_defines.svh =====
// Assertion macros for the maze explorer, emptied for synthesis.
`ifndef MAZE_DFS_EXPLORER_DEFINES_SVH
`define MAZE_DFS_EXPLORER_DEFINES_SVH

`ifndef SYNTHESIS

// ante holds in a cycle -> cons holds in the same cycle
`define MDE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define MDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MDE_ASSERT_IMPL(label, ante, cons, msg)
`define MDE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== src/mde_pkg.sv =====
// Types, codes and constants of the depth-first maze explorer.
package mde_pkg;

    localparam int MAZE_SIZE_DEFAULT = 16;
    localparam int COORD_W           = 4;   // cell coordinate as stored in cur_x/cur_y
    localparam int NB_W              = 5;   // neighbour coordinate, may sit one past 15
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GOAL_X        = 3'd0,
        CFG_GOAL_Y        = 3'd1,
        CFG_START_X       = 3'd2,
        CFG_START_Y       = 3'd3,
        CFG_START_HEADING = 3'd4,
        CFG_MAZE_WIDTH    = 3'd5,
        CFG_MAZE_HEIGHT   = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_LEFT    = 2'd1,
        CMD_RIGHT   = 2'd2,
        CMD_FORWARD = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_EXPLORING = 2'd0,
        STAT_GOAL      = 2'd1,
        STAT_NO_PATH   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    // target direction minus heading
    typedef enum logic [1:0] {
        ROT_AHEAD = 2'd0,
        ROT_CW    = 2'd1,
        ROT_ABOUT = 2'd2,
        ROT_CCW   = 2'd3
    } rot_t;

    typedef enum logic {
        PH_CLEAR,
        PH_RUN
    } phase_t;

    localparam logic [COORD_W-1:0]    GOAL_X_RST        = 4'd7;
    localparam logic [COORD_W-1:0]    GOAL_Y_RST        = 4'd7;
    localparam logic [COORD_W-1:0]    START_X_RST       = 4'd0;
    localparam logic [COORD_W-1:0]    START_Y_RST       = 4'd0;
    localparam logic [1:0]            START_HEADING_RST = 2'd0;
    localparam logic [CFG_DATA_W-1:0] MAZE_WIDTH_RST    = 5'd16;
    localparam logic [CFG_DATA_W-1:0] MAZE_HEIGHT_RST   = 5'd16;

    typedef struct packed {
        logic wall_front;
        logic wall_right;
        logic wall_back;
        logic wall_left;
    } in_item_t;

    typedef struct packed {
        cmd_t    command;
        status_t status;
        logic    last;
    } out_item_t;

    // all results of one step, emitted in order cmd0..cmd[n_last]
    typedef struct packed {
        cmd_t       cmd0;
        cmd_t       cmd1;
        cmd_t       cmd2;
        status_t    status;
        logic [1:0] n_last;
    } desc_t;

endpackage

// ===== src/maze_dfs_explorer.sv =====
// Depth-first maze explorer: visited rows and path stack in memories, read-modify-write per step.
//
//  channel   | ports                              | direction | content
//  ----------+------------------------------------+-----------+-------------------------------
//  sensing   | s_valid s_ready s_data             | in        | four wall bits, robot relative
//  commands  | m_valid m_ready m_data             | out       | command, status, last
//  config    | cfg_wr_en cfg_addr cfg_wr_data     | in        | register write, no wait
//
// In a step, the accept cycle reads three visited rows (split over an even-row and an odd-row
// memory) and the stack top; the decision and write-back follow once the result register is free.
// Each step yields one to three commands, drained one per cycle while m_ready is high through a result register;
// the next step is taken while those still wait, execution holds only when they block it.
// After reset a clearing pass zeroes the visited rows; no transaction is accepted meanwhile,
// configuration writes are.
`include "maze_dfs_explorer_defines.svh"

module maze_dfs_explorer #(
    parameter int MAZE_SIZE = mde_pkg::MAZE_SIZE_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  mde_pkg::in_item_t                   s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output mde_pkg::out_item_t                  m_data,

    input  logic                                cfg_wr_en,
    input  logic [mde_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mde_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int CXW    = $clog2(MAZE_SIZE);
    localparam int SCW    = (CXW > mde_pkg::COORD_W) ? CXW : mde_pkg::COORD_W;
    localparam int ROWS_E = (MAZE_SIZE + 1) / 2;
    localparam int ROWS_O = MAZE_SIZE / 2;
    localparam int REAW   = (ROWS_E > 1) ? $clog2(ROWS_E) : 1;
    localparam int ROAW   = (ROWS_O > 1) ? $clog2(ROWS_O) : 1;
    localparam int CELLS  = MAZE_SIZE * MAZE_SIZE;
    localparam int SAW    = $clog2(CELLS);
    localparam int CNTW   = $clog2(CELLS + 1);
    localparam int NBW    = mde_pkg::NB_W;
    localparam int CW     = mde_pkg::COORD_W;

    localparam logic [NBW:0]    MS_LIM   = (NBW + 1)'(MAZE_SIZE);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(CELLS);
    localparam logic [REAW-1:0] CLR_LAST = REAW'(ROWS_E - 1);
    localparam logic [REAW:0]   CLR_ODD  = (REAW + 1)'(ROWS_O);

    // ---------------------------------------------------------------- registers
    mde_pkg::phase_t    phase_reg, phase_next;
    logic [REAW-1:0]    clr_reg, clr_next;

    logic [CW-1:0]      goal_x_reg, goal_y_reg, start_x_reg, start_y_reg;
    logic [1:0]         start_head_reg;
    logic [4:0]         maze_w_reg, maze_h_reg;

    logic [CW-1:0]      cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [1:0]         heading_reg, heading_next;
    logic [CNTW-1:0]    count_reg, count_next;
    mde_pkg::status_t   finish_reg, finish_next;
    logic [2*CW-1:0]    base_reg, base_next;

    logic               ex_valid_reg;
    mde_pkg::in_item_t  in_reg;

    logic               desc_valid_reg;
    mde_pkg::desc_t     desc_reg, ex_desc;
    logic [1:0]         idx_reg;

    // ---------------------------------------------------------------- memories
    logic [MAZE_SIZE-1:0] vis_even [ROWS_E];
    logic [MAZE_SIZE-1:0] vis_odd  [ROWS_O];
    logic [2*SCW-1:0]     stk_mem  [CELLS];

    logic [MAZE_SIZE-1:0] ev_rd_a_reg, ev_rd_b_reg, od_rd_a_reg, od_rd_b_reg;
    logic [2*SCW-1:0]     stk_rd_reg;

    // ---------------------------------------------------------------- control
    logic clr_active;
    logic in_acc, ex_fire, out_last;
    logic vis_we, stk_we;

    assign in_acc   = s_valid && s_ready;
    assign out_last = (idx_reg == desc_reg.n_last);
    assign ex_fire  = ex_valid_reg && (!desc_valid_reg || (m_ready && out_last));

    always_comb begin
        phase_next = phase_reg;
        clr_next   = clr_reg;
        unique case (phase_reg)
            mde_pkg::PH_CLEAR: begin
                clr_next = clr_reg + REAW'(1);
                if (clr_reg == CLR_LAST) begin
                    phase_next = mde_pkg::PH_RUN;
                end
            end
            mde_pkg::PH_RUN: begin
                phase_next = mde_pkg::PH_RUN;
            end
        endcase
    end

    always_comb begin
        unique case (phase_reg)
            mde_pkg::PH_CLEAR: begin
                clr_active = 1'b1;
                s_ready    = 1'b0;
            end
            mde_pkg::PH_RUN: begin
                clr_active = 1'b0;
                s_ready    = !ex_valid_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------- row addressing
    logic [NBW-1:0] x5, y5, yn, ys;
    logic [3:0]     yrow_c, yrow_n, yrow_s;
    logic           yc_ok, yn_ok, ys_ok, cur_in_grid;

    assign x5     = {1'b0, cur_x_reg};
    assign y5     = {1'b0, cur_y_reg};
    assign yn     = y5 + NBW'(1);
    assign ys     = y5 - NBW'(1);
    assign yrow_c = y5[4:1];
    assign yrow_n = yn[4:1];
    assign yrow_s = ys[4:1];
    assign yc_ok  = {1'b0, y5} < MS_LIM;
    assign yn_ok  = {1'b0, yn} < MS_LIM;
    assign ys_ok  = (cur_y_reg != '0) && ({1'b0, ys} < MS_LIM);
    assign cur_in_grid = ({1'b0, x5} < MS_LIM) && yc_ok;

    logic           ev_re_a, ev_re_b, od_re_a, od_re_b;
    logic [3:0]     ev_ra_a, od_ra_a;
    logic           ev_we, od_we;
    logic [REAW-1:0] ev_waddr;
    logic [ROAW-1:0] od_waddr;
    logic [MAZE_SIZE-1:0] row_c, row_n, row_s, row_mark, vis_wdata;

    // rows y-1 and y+1 share a parity, row y has the other
    assign ev_re_a = in_acc && (cur_y_reg[0] ? ys_ok : yc_ok);
    assign ev_ra_a = cur_y_reg[0] ? yrow_s : yrow_c;
    assign ev_re_b = in_acc && cur_y_reg[0] && yn_ok;
    assign od_re_a = in_acc && (cur_y_reg[0] ? yc_ok : ys_ok);
    assign od_ra_a = cur_y_reg[0] ? yrow_c : yrow_s;
    assign od_re_b = in_acc && !cur_y_reg[0] && yn_ok;

    assign row_c = cur_y_reg[0] ? od_rd_a_reg : ev_rd_a_reg;
    assign row_s = cur_y_reg[0] ? ev_rd_a_reg : od_rd_a_reg;
    assign row_n = cur_y_reg[0] ? ev_rd_b_reg : od_rd_b_reg;

    always_comb begin
        row_mark = row_c;
        if (cur_in_grid) begin
            row_mark[x5[CXW-1:0]] = 1'b1;
        end
    end

    assign vis_wdata = clr_active ? '0 : row_mark;
    assign ev_we     = clr_active || (ex_fire && vis_we && !cur_y_reg[0]);
    assign od_we     = clr_active ? ({1'b0, clr_reg} < CLR_ODD)
                                  : (ex_fire && vis_we && cur_y_reg[0]);
    assign ev_waddr  = clr_active ? clr_reg : yrow_c[REAW-1:0];
    assign od_waddr  = clr_active ? clr_reg[ROAW-1:0] : yrow_c[ROAW-1:0];

    always_ff @(posedge aclk) begin
        if (ev_we) begin
            vis_even[ev_waddr] <= vis_wdata;
        end
        if (ev_re_a) begin
            ev_rd_a_reg <= vis_even[ev_ra_a[REAW-1:0]];
        end
        if (ev_re_b) begin
            ev_rd_b_reg <= vis_even[yrow_n[REAW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (od_we) begin
            vis_odd[od_waddr] <= vis_wdata;
        end
        if (od_re_a) begin
            od_rd_a_reg <= vis_odd[od_ra_a[ROAW-1:0]];
        end
        if (od_re_b) begin
            od_rd_b_reg <= vis_odd[yrow_n[ROAW-1:0]];
        end
    end

    // ---------------------------------------------------------------- path stack
    // entry 0 is the start cell and lives in base_reg; the memory holds entries from 1 up
    logic [CNTW-1:0] cnt0, cnt_m2;
    logic            stk_re, top_is_base;
    logic [NBW-1:0]  top_x, top_y;
    logic [2*SCW-1:0] stk_wdata;

    assign cnt0        = (count_reg == '0) ? CNTW'(1) : count_reg;
    assign cnt_m2      = count_reg - CNTW'(2);
    assign stk_re      = in_acc && (count_reg > CNTW'(2));
    assign top_is_base = (count_reg == CNTW'(2));
    assign top_x = top_is_base ? {1'b0, base_reg[CW-1:0]} : NBW'(stk_rd_reg[SCW-1:0]);
    assign top_y = top_is_base ? {1'b0, base_reg[2*CW-1:CW]} : NBW'(stk_rd_reg[2*SCW-1:SCW]);

    always_ff @(posedge aclk) begin
        if (ex_fire && stk_we) begin
            stk_mem[cnt0[SAW-1:0]] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[cnt_m2[SAW-1:0]];
        end
    end

    // ---------------------------------------------------------------- neighbour search
    function automatic logic row_bit(logic [MAZE_SIZE-1:0] row, logic [NBW-1:0] col);
        logic hit;
        hit = 1'b0;
        if ({1'b0, col} < MS_LIM) begin
            hit = row[col[CXW-1:0]];
        end
        return hit;
    endfunction

    logic [NBW-1:0] nx [4];
    logic [NBW-1:0] ny [4];
    logic [3:0]     nv, vis, wall_rel, wall_abs, ok, adj;
    logic           full, any_ok, any_adj;
    logic [1:0]     mv_dir;

    assign wall_rel = {in_reg.wall_left, in_reg.wall_back, in_reg.wall_right, in_reg.wall_front};
    assign full     = (cnt0 >= CNT_FULL);

    always_comb begin
        nx[mde_pkg::DIR_NORTH] = x5;             ny[mde_pkg::DIR_NORTH] = yn;
        nx[mde_pkg::DIR_EAST]  = x5 + NBW'(1);   ny[mde_pkg::DIR_EAST]  = y5;
        nx[mde_pkg::DIR_SOUTH] = x5;             ny[mde_pkg::DIR_SOUTH] = ys;
        nx[mde_pkg::DIR_WEST]  = x5 - NBW'(1);   ny[mde_pkg::DIR_WEST]  = y5;
        nv[mde_pkg::DIR_NORTH] = 1'b1;
        nv[mde_pkg::DIR_EAST]  = 1'b1;
        nv[mde_pkg::DIR_SOUTH] = (cur_y_reg != '0);
        nv[mde_pkg::DIR_WEST]  = (cur_x_reg != '0);
        vis[mde_pkg::DIR_NORTH] = row_bit(row_n, x5);
        vis[mde_pkg::DIR_EAST]  = row_bit(row_c, nx[mde_pkg::DIR_EAST]);
        vis[mde_pkg::DIR_SOUTH] = row_bit(row_s, x5);
        vis[mde_pkg::DIR_WEST]  = row_bit(row_c, nx[mde_pkg::DIR_WEST]);
        for (int k = 0; k < 4; k++) begin
            wall_abs[k] = wall_rel[2'(k) - heading_reg];
            ok[k]  = nv[k] && !wall_abs[k] && !vis[k] && !full
                     && ({1'b0, nx[k]} < MS_LIM) && ({1'b0, ny[k]} < MS_LIM)
                     && (nx[k] < maze_w_reg) && (ny[k] < maze_h_reg);
            adj[k] = nv[k] && (nx[k] == top_x) && (ny[k] == top_y);
        end
    end

    assign any_ok  = |ok;
    assign any_adj = |adj;

    // first open direction; on a backtrack the direction of the new top
    always_comb begin
        priority if (any_ok ? ok[mde_pkg::DIR_NORTH] : adj[mde_pkg::DIR_NORTH]) begin
            mv_dir = mde_pkg::DIR_NORTH;
        end else if (any_ok ? ok[mde_pkg::DIR_EAST] : adj[mde_pkg::DIR_EAST]) begin
            mv_dir = mde_pkg::DIR_EAST;
        end else if (any_ok ? ok[mde_pkg::DIR_SOUTH] : adj[mde_pkg::DIR_SOUTH]) begin
            mv_dir = mde_pkg::DIR_SOUTH;
        end else begin
            mv_dir = mde_pkg::DIR_WEST;
        end
    end

    assign stk_wdata = {ny[mv_dir][SCW-1:0], nx[mv_dir][SCW-1:0]};

    // turns then one forward move
    mde_pkg::desc_t mv_desc;
    mde_pkg::rot_t  mv_rot;

    assign mv_rot = mde_pkg::rot_t'(mv_dir - heading_reg);

    always_comb begin
        mv_desc        = '{cmd0: mde_pkg::CMD_NONE, cmd1: mde_pkg::CMD_NONE,
                           cmd2: mde_pkg::CMD_NONE, status: mde_pkg::STAT_EXPLORING,
                           n_last: 2'd0};
        unique case (mv_rot)
            mde_pkg::ROT_AHEAD: begin
                mv_desc.cmd0   = mde_pkg::CMD_FORWARD;
                mv_desc.n_last = 2'd0;
            end
            mde_pkg::ROT_CW: begin
                mv_desc.cmd0   = mde_pkg::CMD_RIGHT;
                mv_desc.cmd1   = mde_pkg::CMD_FORWARD;
                mv_desc.n_last = 2'd1;
            end
            mde_pkg::ROT_CCW: begin
                mv_desc.cmd0   = mde_pkg::CMD_LEFT;
                mv_desc.cmd1   = mde_pkg::CMD_FORWARD;
                mv_desc.n_last = 2'd1;
            end
            mde_pkg::ROT_ABOUT: begin
                // about-turn goes right towards west, left otherwise
                mv_desc.cmd0   = (mv_dir == mde_pkg::DIR_WEST) ? mde_pkg::CMD_RIGHT
                                                               : mde_pkg::CMD_LEFT;
                mv_desc.cmd1   = mv_desc.cmd0;
                mv_desc.cmd2   = mde_pkg::CMD_FORWARD;
                mv_desc.n_last = 2'd2;
            end
        endcase
    end

    // ---------------------------------------------------------------- step decision
    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        heading_next = heading_reg;
        count_next   = count_reg;
        finish_next  = finish_reg;
        base_next    = base_reg;
        vis_we       = 1'b0;
        stk_we       = 1'b0;
        ex_desc      = '{cmd0: mde_pkg::CMD_NONE, cmd1: mde_pkg::CMD_NONE,
                         cmd2: mde_pkg::CMD_NONE, status: finish_reg, n_last: 2'd0};
        priority if (finish_reg != mde_pkg::STAT_EXPLORING) begin
            ex_desc.status = finish_reg;
        end else if (cur_x_reg == goal_x_reg && cur_y_reg == goal_y_reg) begin
            finish_next    = mde_pkg::STAT_GOAL;
            ex_desc.status = mde_pkg::STAT_GOAL;
        end else begin
            vis_we = cur_in_grid;
            if (count_reg == '0) begin
                base_next = {cur_y_reg, cur_x_reg};
            end
            priority if (any_ok) begin
                stk_we       = 1'b1;
                count_next   = cnt0 + CNTW'(1);
                heading_next = mv_dir;
                cur_x_next   = nx[mv_dir][CW-1:0];
                cur_y_next   = ny[mv_dir][CW-1:0];
                ex_desc      = mv_desc;
            end else if (cnt0 == CNTW'(1)) begin
                count_next     = '0;
                finish_next    = mde_pkg::STAT_NO_PATH;
                ex_desc.status = mde_pkg::STAT_NO_PATH;
            end else if (any_adj) begin
                count_next   = cnt0 - CNTW'(1);
                heading_next = mv_dir;
                cur_x_next   = nx[mv_dir][CW-1:0];
                cur_y_next   = ny[mv_dir][CW-1:0];
                ex_desc      = mv_desc;
            end else begin
                // top not adjacent: jump there without a command
                count_next     = cnt0 - CNTW'(1);
                cur_x_next     = top_x[CW-1:0];
                cur_y_next     = top_y[CW-1:0];
                ex_desc.status = mde_pkg::STAT_EXPLORING;
            end
        end
    end

    // ---------------------------------------------------------------- state registers
    logic cfg_idle;
    assign cfg_idle = (count_reg == '0) && (finish_reg == mde_pkg::STAT_EXPLORING);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= mde_pkg::PH_CLEAR;
            clr_reg        <= '0;
            goal_x_reg     <= mde_pkg::GOAL_X_RST;
            goal_y_reg     <= mde_pkg::GOAL_Y_RST;
            start_x_reg    <= mde_pkg::START_X_RST;
            start_y_reg    <= mde_pkg::START_Y_RST;
            start_head_reg <= mde_pkg::START_HEADING_RST;
            maze_w_reg     <= mde_pkg::MAZE_WIDTH_RST;
            maze_h_reg     <= mde_pkg::MAZE_HEIGHT_RST;
            cur_x_reg      <= mde_pkg::START_X_RST;
            cur_y_reg      <= mde_pkg::START_Y_RST;
            heading_reg    <= mde_pkg::START_HEADING_RST;
            count_reg      <= '0;
            finish_reg     <= mde_pkg::STAT_EXPLORING;
            ex_valid_reg   <= 1'b0;
            desc_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            phase_reg <= phase_next;
            clr_reg   <= clr_next;

            if (in_acc) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end

            if (ex_fire) begin
                cur_x_reg      <= cur_x_next;
                cur_y_reg      <= cur_y_next;
                heading_reg    <= heading_next;
                count_reg      <= count_next;
                finish_reg     <= finish_next;
                desc_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end else if (m_valid && m_ready) begin
                if (out_last) begin
                    desc_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    mde_pkg::CFG_GOAL_X:      goal_x_reg <= cfg_wr_data[CW-1:0];
                    mde_pkg::CFG_GOAL_Y:      goal_y_reg <= cfg_wr_data[CW-1:0];
                    mde_pkg::CFG_START_X: begin
                        start_x_reg <= cfg_wr_data[CW-1:0];
                        if (cfg_idle) begin
                            cur_x_reg <= cfg_wr_data[CW-1:0];
                        end
                    end
                    mde_pkg::CFG_START_Y: begin
                        start_y_reg <= cfg_wr_data[CW-1:0];
                        if (cfg_idle) begin
                            cur_y_reg <= cfg_wr_data[CW-1:0];
                        end
                    end
                    mde_pkg::CFG_START_HEADING: begin
                        start_head_reg <= cfg_wr_data[1:0];
                        if (cfg_idle) begin
                            heading_reg <= cfg_wr_data[1:0];
                        end
                    end
                    mde_pkg::CFG_MAZE_WIDTH:  maze_w_reg <= cfg_wr_data;
                    mde_pkg::CFG_MAZE_HEIGHT: maze_h_reg <= cfg_wr_data;
                    default: ;  // drop writes beyond the register list
                endcase
            end
        end
    end

    // payload holding registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            in_reg <= s_data;
        end
        if (ex_fire) begin
            desc_reg <= ex_desc;
            base_reg <= base_next;
        end
    end

    // ---------------------------------------------------------------- result channel
    assign m_valid = desc_valid_reg;

    always_comb begin
        unique case (idx_reg)
            2'd0:    m_data.command = desc_reg.cmd0;
            2'd1:    m_data.command = desc_reg.cmd1;
            default: m_data.command = desc_reg.cmd2;
        endcase
        m_data.status = desc_reg.status;
        m_data.last   = out_last;
    end

    // ---------------------------------------------------------------- checks
    `MDE_ASSERT_NEXT(a_acc_held, s_valid && s_ready, ex_valid_reg, "accepted transaction lost before execution")
    `MDE_ASSERT_IMPL(a_clear_quiet, phase_reg == mde_pkg::PH_CLEAR, !ex_valid_reg && !desc_valid_reg, "activity during clearing pass")
    `MDE_ASSERT_IMPL(a_stack_bound, 1'b1, count_reg <= CNT_FULL, "path stack count beyond depth")
    `MDE_ASSERT_NEXT(a_finish_hold, finish_reg != mde_pkg::STAT_EXPLORING, $stable(finish_reg), "finish status changed after end of search")
    `MDE_ASSERT_IMPL(a_idx_range, desc_valid_reg, idx_reg <= desc_reg.n_last, "result index past final command")

endmodule

// ===== tb/sv/maze_dfs_explorer_checker.sv =====
// Command checker for the maze explorer: tracks registers, predicts each step's commands, compares.
module maze_dfs_explorer_checker
    import mde_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    cmd_backlog,
    output logic                  run_finished,
    output int                    mismatch_count
);

    localparam int GRID  = MAZE_SIZE_DEFAULT;
    localparam int CELLS = GRID * GRID;

    logic [3:0] goal_x, goal_y, start_x, start_y;
    dir_t       start_heading;
    logic [4:0] maze_w, maze_h;

    logic [3:0]  pos_x, pos_y;
    dir_t        heading;
    bit          visited [CELLS];
    logic [7:0]  trail [CELLS];     // {y, x} of each cell on the current path
    int unsigned trail_depth;
    status_t     outcome;

    out_item_t cmds_due[$];

    task automatic emit_cmd(input cmd_t c, input status_t st, input logic lst);
        out_item_t r;
        r.command = c;
        r.status  = st;
        r.last    = lst;
        cmds_due = {cmds_due, r};
    endtask

    // Neighbour in absolute direction d; fails only when stepping below row or column zero.
    function automatic bit step_to(input logic [3:0] x, input logic [3:0] y, input dir_t d,
                                   output int nx, output int ny);
        nx = int'(x);
        ny = int'(y);
        case (d)
            DIR_NORTH: ny = int'(y) + 1;
            DIR_EAST:  nx = int'(x) + 1;
            DIR_SOUTH: begin
                if (y == 4'd0) return 1'b0;
                ny = int'(y) - 1;
            end
            default: begin
                if (x == 4'd0) return 1'b0;
                nx = int'(x) - 1;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic drive_to(input dir_t d);
        logic [1:0] diff;
        logic [1:0] hd;
        int         nx, ny;
        diff = d - heading;
        case (diff)
            ROT_CW: begin
                emit_cmd(CMD_RIGHT, STAT_EXPLORING, 1'b0);
                hd = heading + 2'd1;
                heading = dir_t'(hd);
            end
            ROT_CCW: begin
                emit_cmd(CMD_LEFT, STAT_EXPLORING, 1'b0);
                hd = heading - 2'd1;
                heading = dir_t'(hd);
            end
            ROT_ABOUT: begin
                // about-turn: rightwards only when the new heading is west
                if (d == DIR_WEST) begin
                    emit_cmd(CMD_RIGHT, STAT_EXPLORING, 1'b0);
                    emit_cmd(CMD_RIGHT, STAT_EXPLORING, 1'b0);
                end else begin
                    emit_cmd(CMD_LEFT, STAT_EXPLORING, 1'b0);
                    emit_cmd(CMD_LEFT, STAT_EXPLORING, 1'b0);
                end
                heading = d;
            end
            default: ;
        endcase
        emit_cmd(CMD_FORWARD, STAT_EXPLORING, 1'b1);
        if (step_to(pos_x, pos_y, d, nx, ny)) begin
            pos_x = nx[3:0];
            pos_y = ny[3:0];
        end
    endtask

    task automatic explore_step(input in_item_t w);
        logic [3:0] sensed;     // indexed by rotation: front, right, back, left
        logic [1:0] rel;
        logic [7:0] top;
        int         nx, ny, lim_w, lim_h;
        dir_t       d;
        sensed = {w.wall_left, w.wall_back, w.wall_right, w.wall_front};
        lim_w  = (maze_w > GRID) ? GRID : int'(maze_w);
        lim_h  = (maze_h > GRID) ? GRID : int'(maze_h);
        if (outcome != STAT_EXPLORING) begin
            emit_cmd(CMD_NONE, outcome, 1'b1);
            return;
        end
        if (pos_x == goal_x && pos_y == goal_y) begin
            outcome = STAT_GOAL;
            emit_cmd(CMD_NONE, STAT_GOAL, 1'b1);
            return;
        end
        if (trail_depth == 0) begin
            trail[0]    = {pos_y, pos_x};
            trail_depth = 1;
        end
        visited[{pos_y, pos_x}] = 1'b1;
        for (int i = 0; i < 4; i++) begin
            d   = dir_t'(i);
            rel = d - heading;
            if (sensed[rel]) continue;
            if (!step_to(pos_x, pos_y, d, nx, ny)) continue;
            if (nx >= lim_w || ny >= lim_h || nx >= GRID || ny >= GRID) continue;
            if (visited[ny * GRID + nx] || trail_depth >= CELLS) continue;
            trail[trail_depth] = {ny[3:0], nx[3:0]};
            trail_depth++;
            drive_to(d);
            return;
        end
        // dead end: drop the top and head back
        trail_depth--;
        if (trail_depth == 0) begin
            outcome = STAT_NO_PATH;
            emit_cmd(CMD_NONE, STAT_NO_PATH, 1'b1);
            return;
        end
        top = trail[trail_depth - 1];
        for (int i = 0; i < 4; i++) begin
            if (step_to(pos_x, pos_y, dir_t'(i), nx, ny) && nx == int'(top[3:0])
                    && ny == int'(top[7:4])) begin
                drive_to(dir_t'(i));
                return;
            end
        end
        pos_x = top[3:0];
        pos_y = top[7:4];
        emit_cmd(CMD_NONE, STAT_EXPLORING, 1'b1);
    endtask

    always @(posedge aclk) begin : track
        out_item_t want;
        bit        idle;
        if (!aresetn) begin
            goal_x        = GOAL_X_RST;
            goal_y        = GOAL_Y_RST;
            start_x       = START_X_RST;
            start_y       = START_Y_RST;
            start_heading = dir_t'(START_HEADING_RST);
            maze_w        = MAZE_WIDTH_RST;
            maze_h        = MAZE_HEIGHT_RST;
            pos_x         = START_X_RST;
            pos_y         = START_Y_RST;
            heading       = dir_t'(START_HEADING_RST);
            for (int i = 0; i < CELLS; i++) visited[i] = 1'b0;
            trail_depth    = 0;
            outcome        = STAT_EXPLORING;
            mismatch_count = 0;
            cmds_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (cmds_due.size() == 0) begin
                    mismatch_count++;
                    $error("unexpected command transaction: command %0d status %0d last %0d",
                           m_data.command, m_data.status, m_data.last);
                end else begin
                    want = cmds_due.pop_front();
                    if (m_data.command !== want.command) begin
                        mismatch_count++;
                        $error("command: expected %0d, actual %0d", want.command,
                               m_data.command);
                    end
                    if (m_data.status !== want.status) begin
                        mismatch_count++;
                        $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    end
                    if (m_data.last !== want.last) begin
                        mismatch_count++;
                        $error("last: expected %0d, actual %0d", want.last, m_data.last);
                    end
                end
            end
            if (cfg_wr_en) begin
                // start registers also move the robot while nothing has been explored
                idle = (trail_depth == 0) && (outcome == STAT_EXPLORING);
                case (cfg_addr)
                    CFG_GOAL_X: goal_x = cfg_wr_data[3:0];
                    CFG_GOAL_Y: goal_y = cfg_wr_data[3:0];
                    CFG_START_X: begin
                        start_x = cfg_wr_data[3:0];
                        if (idle) pos_x = start_x;
                    end
                    CFG_START_Y: begin
                        start_y = cfg_wr_data[3:0];
                        if (idle) pos_y = start_y;
                    end
                    CFG_START_HEADING: begin
                        start_heading = dir_t'(cfg_wr_data[1:0]);
                        if (idle) heading = start_heading;
                    end
                    CFG_MAZE_WIDTH:  maze_w = cfg_wr_data;
                    CFG_MAZE_HEIGHT: maze_h = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) explore_step(s_data);
        end
        cmd_backlog  <= cmds_due.size();
        run_finished <= (outcome != STAT_EXPLORING);
    end

endmodule

// ===== tb/sv/maze_dfs_explorer_tb.sv =====
// Testbench top for the maze explorer: clock, reset, sensing stimulus, register writes, verdict.
module maze_dfs_explorer_tb;
    import mde_pkg::*;

    // index past the register file, must be ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [3:0] ORIGIN_X = 4'd1;
    localparam logic [3:0] ORIGIN_Y = 4'd0;
    // opening walks, first step in the lowest nibble; each nibble is front, right, back, left
    localparam logic [79:0] OPENING_WALLS = {
        4'b1001, 4'b0110, 4'b0101, 4'b1010, 4'b0011, 4'b1100, 4'b0001, 4'b0010,
        4'b0100, 4'b1000, 4'b0000, 4'b1110, 4'b1101, 4'b1011, 4'b0111, 4'b1111,
        4'b0000, 4'b0000, 4'b0000, 4'b0000
    };

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_item_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int   gap_pct     = 0;
    int   stall_pct   = 0;
    int   hold_len    = 0;
    int   hold_ticket = 0;
    int   hold_seen   = 0;
    int   hold_left   = 0;
    int   cmd_backlog;
    int   mismatch_count;
    logic run_finished;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    maze_dfs_explorer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    maze_dfs_explorer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .cmd_backlog    (cmd_backlog),
        .run_finished   (run_finished),
        .mismatch_count (mismatch_count)
    );

    // command sink: random stalls, plus a long hold-off whenever a new ticket is issued
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = hold_len;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
    endtask

    task automatic send_walls(input in_item_t w);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic in_item_t rand_walls(input int pct);
        in_item_t w;
        w.wall_front = ($urandom_range(99) < pct);
        w.wall_right = ($urandom_range(99) < pct);
        w.wall_back  = ($urandom_range(99) < pct);
        w.wall_left  = ($urandom_range(99) < pct);
        return w;
    endfunction

    // hold the sensing channel until every predicted command has gone out
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (cmd_backlog != 0);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input int gap, input int stall, input int items, input int pct,
                             input int hold);
        drain();
        write_reg(CFG_MAZE_WIDTH, w);
        write_reg(CFG_MAZE_HEIGHT, h);
        cfg_wr_en <= 1'b0;
        gap_pct   = gap;
        stall_pct = stall;
        if (hold > 0) begin
            hold_len = hold;
            hold_ticket++;
        end
        repeat (items) send_walls(rand_walls(pct));
    endtask

    initial begin
        int   n;
        logic goal_ending;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // nothing explored yet, so the start writes also place the robot
        write_reg(CFG_SPARE, 5'd31);
        write_reg(CFG_GOAL_X, 5'd0);
        write_reg(CFG_GOAL_Y, 5'd0);
        write_reg(CFG_GOAL_X, 5'd15);
        write_reg(CFG_GOAL_Y, 5'd15);
        write_reg(CFG_START_X, 5'd15);
        write_reg(CFG_START_Y, 5'd15);
        write_reg(CFG_START_HEADING, CFG_DATA_W'(DIR_NORTH));
        write_reg(CFG_START_X, CFG_DATA_W'(ORIGIN_X));
        write_reg(CFG_START_Y, CFG_DATA_W'(ORIGIN_Y));
        write_reg(CFG_START_HEADING, CFG_DATA_W'(DIR_WEST));
        write_reg(CFG_MAZE_WIDTH, 5'd15);
        write_reg(CFG_MAZE_HEIGHT, 5'd16);
        cfg_wr_en <= 1'b0;

        for (int i = 0; i < 20; i++) send_walls(in_item_t'(OPENING_WALLS[i*4 +: 4]));

        // goal column or row stays outside the maze so the walk keeps going
        run_phase(5'd15, 5'd16, 0, 0, 60, 25, 0);
        drain();
        write_reg(CFG_START_X, CFG_DATA_W'($urandom_range(15)));
        write_reg(CFG_START_Y, CFG_DATA_W'($urandom_range(15)));
        write_reg(CFG_START_HEADING, CFG_DATA_W'($urandom_range(3)));
        cfg_wr_en <= 1'b0;
        run_phase(5'd31, 5'd15, 45, 0, 60, 25, 0);
        run_phase(5'd15, 5'd31, 0, 45, 60, 25, 150);
        run_phase(5'd1, 5'd16, 22, 22, 10, 25, 0);
        run_phase(5'd16, 5'd1, 22, 22, 10, 25, 0);
        run_phase(5'd15, 5'd16, 22, 22, 70, 35, 0);
        run_phase(5'd16, 5'd15, 0, 0, 60, 15, 0);

        // shut the maze and unwind to the origin: it ends either on the goal or with no path
        goal_ending = 1'($urandom_range(1));
        drain();
        if (goal_ending) begin
            write_reg(CFG_GOAL_X, CFG_DATA_W'(ORIGIN_X));
            write_reg(CFG_GOAL_Y, CFG_DATA_W'(ORIGIN_Y));
            cfg_wr_en <= 1'b0;
        end
        run_phase(5'd0, 5'd0, 22, 22, 0, 25, 0);
        n = 0;
        while (!run_finished && n < 300) begin
            send_walls(rand_walls(25));
            n++;
        end
        repeat (6) send_walls(rand_walls(50));

        drain();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && cmd_backlog == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
